/* hdl/bae_pkg.sv */
package bae_pkg;

	localparam int MODE_W = 4;
	localparam int POS_W = 8;
	localparam int OPV_W = 32;
	localparam int RES_W = 32;
	localparam int FIDX_W = 8;
	localparam int CNT_OUT_W = 9;
	localparam int IN_TDATA_W = 48;
	localparam int OUT_TDATA_W = 56;

	localparam logic [MODE_W-1:0] MODE_PUSH = 4'd0;
	localparam logic [MODE_W-1:0] MODE_GET = 4'd1;
	localparam logic [MODE_W-1:0] MODE_SET = 4'd2;
	localparam logic [MODE_W-1:0] MODE_FIND = 4'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 4'd4;
	localparam logic [MODE_W-1:0] MODE_INSERT = 4'd5;
	localparam logic [MODE_W-1:0] MODE_POPFRONT = 4'd6;
	localparam logic [MODE_W-1:0] MODE_POPBACK = 4'd7;
	localparam logic [MODE_W-1:0] MODE_SORT = 4'd8;
	localparam logic [MODE_W-1:0] MODE_BSEARCH = 4'd9;
	localparam logic [MODE_W-1:0] MODE_REVERSE = 4'd10;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 4'd11;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_WRITE,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN,
		OP_CMPX,
		OP_SWAP,
		OP_LOAD,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     phase;
	} cell_ctl_t;

endpackage

/* hdl/bae_cell.sv */
module bae_cell #(
	parameter int VW = 32,
	parameter int CW = 9,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  bae_pkg::cell_ctl_t  ctl,
	input  logic [CW-1:0]       pos,
	input  logic [CW-1:0]       cnt,
	input  logic [VW-1:0]       wr,
	input  logic [VW-1:0]       left,
	input  logic [VW-1:0]       right,
	input  logic [VW-1:0]       rd_next,
	output logic [VW-1:0]       value,
	output logic [VW-1:0]       rd
);

	localparam logic [CW:0] IDXV = (CW+1)'(IDX);
	localparam logic [CW:0] IDXP = (CW+1)'(IDX + 1);
	localparam logic        PAR = 1'((IDX % 2) != 0);
	localparam logic        HAS_L = (IDX > 0);

	logic [VW-1:0] value_q;
	logic [VW-1:0] rd_q;
	logic [CW:0]   posx;
	logic [CW:0]   cntx;
	logic          lower;
	logic          upper;

	assign posx = {1'b0, pos};
	assign cntx = {1'b0, cnt};
	assign lower = (PAR == ctl.phase) && (IDXP < cntx);
	assign upper = HAS_L && (PAR != ctl.phase) && (IDXV < cntx);

	always_ff @(posedge clk) begin
		case (ctl.op)
			bae_pkg::OP_WRITE: begin
				if (IDXV == posx) value_q <= wr;
			end
			bae_pkg::OP_SHIFT_UP: begin
				if (IDXV == posx) value_q <= wr;
				else if (IDXV > posx && IDXV <= cntx) value_q <= left;
			end
			bae_pkg::OP_SHIFT_DOWN: begin
				if (IDXV >= posx && IDXP < cntx) value_q <= right;
			end
			bae_pkg::OP_CMPX: begin
				if (lower && $signed(right) < $signed(value_q)) value_q <= right;
				else if (upper && $signed(value_q) < $signed(left)) value_q <= left;
			end
			bae_pkg::OP_SWAP: begin
				if (lower) value_q <= right;
				else if (upper) value_q <= left;
			end
			bae_pkg::OP_LOAD: rd_q <= value_q;
			bae_pkg::OP_ROT: rd_q <= rd_next;
			default: begin
			end
		endcase
	end

	assign value = value_q;
	assign rd = rd_q;

endmodule

/* hdl/bounded_array_engine_core.sv */
// Channel  Direction  Transaction payload
// s_axis   in         one request: mode, position, operand_value
// m_axis   out        one result: result_value, found_index, found, status, element_count
//
// One request at a time; push, set, insert, clear pass through execute, then finish and output.
// Get, remove and pops rotate a readout chain up to the read index.
// Find scans the chain until a match or the last element; sort and reverse take count cell phases.
// Binary search rotates the readout chain per probe.
// Reset clears count and the handshakes; cell contents stay undefined.
// A stalled result holds in the output register; the next request may enter.
module bounded_array_engine_core #(
	parameter int CAPACITY = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [3:0] mode, [11:4] position, [43:12] operand_value
	input  logic [bae_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] result_value, [39:32] found_index, [40] found, [42:41] status,
	// [51:43] element_count
	output logic [bae_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int N = CAPACITY;
	localparam int VW = VALUE_WIDTH;
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int PW = (CW > 8) ? CW : 8;
	localparam int SW = IW + 2;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EXEC = 7'b0000010,
		ST_ROT  = 7'b0000100,
		ST_BS   = 7'b0001000,
		ST_FIND = 7'b0010000,
		ST_SORT = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [bae_pkg::MODE_W-1:0] mode_q;
	logic [bae_pkg::POS_W-1:0]  pos_q;
	logic [VW-1:0]              val_q;
	logic [CW-1:0]              count_q;
	logic [IW-1:0]              head_q;
	logic [IW-1:0]              target_q;
	logic [CW-1:0]              rounds_q;
	logic                       phase_q;
	logic                       swap_q;
	logic signed [SW-1:0]       lo_q;
	logic signed [SW-1:0]       hi_q;
	logic [VW-1:0]              res_val_q;
	logic [IW-1:0]              fidx_q;
	logic                       found_q;
	logic [1:0]                 stat_q;
	logic [bae_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                       m_tvalid_q;

	bae_pkg::cell_ctl_t ctl;
	logic [CW-1:0]      cell_pos;
	logic [VW-1:0]      vals [N];
	logic [VW-1:0]      rds [N];

	logic signed [63:0] op_ext;
	logic [VW-1:0]      norm_val;
	logic [PW-1:0]      posx;
	logic [PW-1:0]      cntx;
	logic               bad_idx;
	logic               full;
	logic [IW-1:0]      head_nx;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] mid;
	logic signed [SW-1:0] cnt_s;
	logic [VW-1:0]      rd0;
	logic signed [63:0] res_ext;
	logic [bae_pkg::FIDX_W-1:0] fidx_out;
	logic [bae_pkg::CNT_OUT_W-1:0] cnt_out;
	logic               out_free;

	assign op_ext = 64'(signed'(s_tdata[43:12]));
	assign norm_val = op_ext[VW-1:0];
	assign posx = PW'(pos_q);
	assign cntx = PW'(count_q);
	assign bad_idx = posx >= cntx;
	assign full = count_q == CW'(N);
	assign head_nx = (head_q == IW'(N - 1)) ? '0 : head_q + 1'b1;
	assign sum = lo_q + hi_q;
	assign mid = (sum < 0) ? '0 : (sum >>> 1);
	assign cnt_s = SW'(count_q);
	assign rd0 = rds[0];
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		ctl.op = bae_pkg::OP_NONE;
		ctl.phase = phase_q;
		cell_pos = CW'(pos_q);
		case (state_q)
			ST_EXEC: begin
				case (mode_q)
					bae_pkg::MODE_PUSH: begin
						cell_pos = count_q;
						if (!full) ctl.op = bae_pkg::OP_WRITE;
					end
					bae_pkg::MODE_SET: if (!bad_idx) ctl.op = bae_pkg::OP_WRITE;
					bae_pkg::MODE_INSERT: begin
						if (posx <= cntx && !full) ctl.op = bae_pkg::OP_SHIFT_UP;
					end
					bae_pkg::MODE_GET, bae_pkg::MODE_REMOVE, bae_pkg::MODE_FIND,
					bae_pkg::MODE_POPFRONT, bae_pkg::MODE_POPBACK,
					bae_pkg::MODE_BSEARCH: ctl.op = bae_pkg::OP_LOAD;
					default: ctl.op = bae_pkg::OP_NONE;
				endcase
			end
			ST_ROT: begin
				cell_pos = CW'(target_q);
				if (head_q != target_q) ctl.op = bae_pkg::OP_ROT;
				else if (mode_q == bae_pkg::MODE_REMOVE || mode_q == bae_pkg::MODE_POPFRONT
					|| mode_q == bae_pkg::MODE_POPBACK) ctl.op = bae_pkg::OP_SHIFT_DOWN;
			end
			ST_FIND: begin
				if (rd0 != val_q) ctl.op = bae_pkg::OP_ROT;
			end
			ST_SORT: ctl.op = swap_q ? bae_pkg::OP_SWAP : bae_pkg::OP_CMPX;
			default: ctl.op = bae_pkg::OP_NONE;
		endcase
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [VW-1:0] left_v;
		logic [VW-1:0] right_v;
		if (i == 0) begin : g_l0
			assign left_v = '0;
		end else begin : g_l
			assign left_v = vals[i-1];
		end
		if (i == N - 1) begin : g_r0
			assign right_v = '0;
		end else begin : g_r
			assign right_v = vals[i+1];
		end
		bae_cell #(.VW(VW), .CW(CW), .IDX(i)) u_cell (
			.clk(clk),
			.ctl(ctl),
			.pos(cell_pos),
			.cnt(count_q),
			.wr(val_q),
			.left(left_v),
			.right(right_v),
			.rd_next(rds[(i + 1) % N]),
			.value(vals[i]),
			.rd(rds[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					case (mode_q)
						bae_pkg::MODE_PUSH: if (!full) count_q <= count_q + 1'b1;
						bae_pkg::MODE_GET, bae_pkg::MODE_REMOVE: begin
							if (!bad_idx) state_q <= ST_ROT;
						end
						bae_pkg::MODE_FIND: if (count_q != '0) state_q <= ST_FIND;
						bae_pkg::MODE_INSERT: begin
							if (posx <= cntx && !full) count_q <= count_q + 1'b1;
						end
						bae_pkg::MODE_POPFRONT, bae_pkg::MODE_POPBACK: begin
							if (count_q != '0) state_q <= ST_ROT;
						end
						bae_pkg::MODE_SORT, bae_pkg::MODE_REVERSE: begin
							if (count_q > CW'(1)) state_q <= ST_SORT;
						end
						bae_pkg::MODE_BSEARCH: if (count_q != '0) state_q <= ST_BS;
						bae_pkg::MODE_CLEAR: count_q <= '0;
						default: state_q <= ST_FIN;
					endcase
				end
				ST_ROT: begin
					if (head_q == target_q) begin
						state_q <= ST_FIN;
						if (mode_q == bae_pkg::MODE_BSEARCH) begin
							if (rd0 != val_q && lo_q < hi_q) state_q <= ST_BS;
						end else if (mode_q != bae_pkg::MODE_GET) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				ST_BS: begin
					state_q <= (mid >= cnt_s) ? ST_FIN : ST_ROT;
				end
				ST_FIND: begin
					if (rd0 == val_q || CW'(head_q) + 1'b1 == count_q) state_q <= ST_FIN;
				end
				ST_SORT: begin
					if (rounds_q + 1'b1 == count_q) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q <= s_tdata[3:0];
				pos_q <= s_tdata[11:4];
				val_q <= norm_val;
			end
			ST_EXEC: begin
				res_val_q <= '0;
				fidx_q <= '0;
				found_q <= 1'b0;
				stat_q <= bae_pkg::STAT_OK;
				head_q <= '0;
				rounds_q <= '0;
				phase_q <= 1'b0;
				swap_q <= mode_q == bae_pkg::MODE_REVERSE;
				lo_q <= '0;
				hi_q <= cnt_s - 1'b1;
				target_q <= IW'(pos_q);
				case (mode_q)
					bae_pkg::MODE_PUSH: if (full) stat_q <= bae_pkg::STAT_FULL;
					bae_pkg::MODE_GET, bae_pkg::MODE_SET, bae_pkg::MODE_REMOVE: begin
						if (bad_idx) stat_q <= bae_pkg::STAT_BAD_INDEX;
					end
					bae_pkg::MODE_INSERT: begin
						if (posx > cntx) stat_q <= bae_pkg::STAT_BAD_INDEX;
						else if (full) stat_q <= bae_pkg::STAT_FULL;
					end
					bae_pkg::MODE_POPFRONT: begin
						target_q <= '0;
						if (count_q == '0) stat_q <= bae_pkg::STAT_EMPTY;
					end
					bae_pkg::MODE_POPBACK: begin
						target_q <= IW'(count_q - 1'b1);
						if (count_q == '0) stat_q <= bae_pkg::STAT_EMPTY;
					end
					default: begin
					end
				endcase
			end
			ST_ROT: begin
				if (head_q != target_q) head_q <= head_nx;
				else if (mode_q == bae_pkg::MODE_BSEARCH) begin
					if (rd0 == val_q) begin
						found_q <= 1'b1;
						fidx_q <= target_q;
					end else if ($signed(val_q) < $signed(rd0)) hi_q <= mid - 1'b1;
					else lo_q <= mid + 1'b1;
				end else res_val_q <= rd0;
			end
			ST_BS: target_q <= IW'(mid);
			ST_FIND: begin
				if (rd0 == val_q) begin
					found_q <= 1'b1;
					fidx_q <= head_q;
				end else head_q <= head_nx;
			end
			ST_SORT: begin
				rounds_q <= rounds_q + 1'b1;
				phase_q <= !phase_q;
			end
			ST_FIN: begin
				if (out_free) m_tdata_q <= {4'd0, cnt_out, stat_q, found_q, fidx_out,
					res_ext[31:0]};
			end
			default: begin
			end
		endcase
	end

	assign res_ext = 64'(signed'(res_val_q));
	assign fidx_out = bae_pkg::FIDX_W'(fidx_q);
	assign cnt_out = bae_pkg::CNT_OUT_W'(count_q);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("count above capacity");
	a_sort_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SORT |-> count_q > CW'(1))
		else $error("sort phase on short list");
	a_rot_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT |-> head_q <= IW'(N - 1))
		else $error("readout head out of range");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FIN))
		else $error("result without finish");

endmodule
